// ===== rtl/dwsm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Watchpoint slot manager package
// Status codes, DR7 constants, sequencer states and chunk sizing helpers.
// ----------------------------------------------------------------------------
package dwsm_pkg;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_READ     = 3'd1,
      ST_FULL     = 3'd2,
      ST_NOMATCH  = 3'd3,
      ST_BADLEN   = 3'd4,
      ST_OVERFLOW = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHUNK,
      S_SCAN,
      S_APPLY,
      S_COMMIT,
      S_RESP
   } state_type;

   localparam logic [31:0] SLOWDOWN_BIT  = 32'h0000_0100;
   localparam logic [31:0] RESERVED_BITS = 32'h0000_FC00;
   localparam logic [15:0] COUNT_MAX     = 16'hFFFF;
   localparam logic [1:0]  TYPE_EXEC     = 2'd0;
   localparam logic [1:0]  TYPE_WRITE    = 2'd1;
   localparam logic [1:0]  TYPE_READ     = 2'd2;
   localparam logic [1:0]  TYPE_RW       = 2'd3;

   // chunk size (1,2,4,8) as log2 from table row and alignment
   function automatic logic [1:0] chunk_log2(input logic [1:0] row, input logic [2:0] align);
      logic [1:0] r;
      begin
         r = 2'd0;
         if (align[0] == 1'b0 && row != 2'd0) begin
            if (align[1] == 1'b1 || row == 2'd1) r = 2'd1;
            else if (align[2] == 1'b1 || row == 2'd2) r = 2'd2;
            else r = 2'd3;
         end
         return r;
      end
   endfunction

   function automatic logic [3:0] rw_len_bits(input logic [1:0] lg, input logic [1:0] atype);
      logic [3:0] v;
      begin
         v = 4'd0;
         if (atype == TYPE_WRITE) v[1:0] = 2'd1;
         else if (atype == TYPE_RW) v[1:0] = 2'd3;
         case (lg)
            2'd1: v[3:2] = 2'd1;
            2'd2: v[3:2] = 2'd3;
            2'd3: v[3:2] = 2'd2;
            default: v[3:2] = 2'd0;
         endcase
         return v;
      end
   endfunction

endpackage

// ===== rtl/debug_watchpoint_slot_manager.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Debug watchpoint slot manager
// Reference-counted watch slots with a DR7 control mirror, updated through a
// shadow copy that commits only when every chunk of a request succeeds.
// ----------------------------------------------------------------------------
// Sequence: a rejected request goes straight to commit and response; otherwise
// each chunk is sized, scanned with one slot compare per cycle in the shared
// scan unit, and applied; a stalled earlier response adds its wait.
// Throughput: one request at a time; req_ready is high only when idle.
// Reset: synchronous; clears all slots, the mirror, and sets wide length on.
module debug_watchpoint_slot_manager #(
   parameter int SLOTS          = 4,
   parameter int MAX_REGION_LEN = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [63:0] req_watch_address,
   input  logic [6:0]  req_region_length,
   input  logic [1:0]  req_access_type,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_control_word,
   output logic [2:0]  rsp_slots_used,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_wide_length_enable
);

   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam int LW = $clog2(MAX_REGION_LEN + 1);

   dwsm_pkg::state_type state_ff, state_in;

   logic [63:0] addr_ff   [SLOTS];
   logic [15:0] count_ff  [SLOTS];
   logic [63:0] saddr_ff  [SLOTS];
   logic [15:0] scount_ff [SLOTS];
   logic [31:0] ctrl_ff, sctrl_ff;
   logic        wide_ff;

   logic        kind_ff;
   logic [1:0]  type_ff;
   logic [63:0] caddr_ff;
   logic [LW-1:0] len_ff;
   logic [3:0]  nib_ff;
   logic [3:0]  csize_ff;
   logic [SW-1:0] idx_ff;
   logic        match_ff, free_ff;
   logic [SW-1:0] midx_ff, fidx_ff;
   logic [2:0]  status_ff;
   logic        rsp_valid_ff;
   logic [2:0]  rsp_status_ff;
   logic [31:0] rsp_ctrl_ff;
   logic [2:0]  rsp_used_ff;

   logic        last_slot;
   logic [3:0]  maxw;
   logic [2:0]  align;
   logic [3:0]  tl;
   logic [1:0]  row, lg;
   logic        hit;
   logic [3:0]  slot_nib;
   logic [CW-1:0] used_cnt;

   assign req_ready = (state_ff == dwsm_pkg::S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_control_word = rsp_ctrl_ff;
   assign rsp_slots_used   = rsp_used_ff;

   assign last_slot = (idx_ff == SW'(SLOTS - 1));
   assign maxw      = wide_ff ? 4'd8 : 4'd4;
   assign align     = caddr_ff[2:0] & 3'(maxw - 4'd1);
   assign tl        = (len_ff > LW'(maxw)) ? (maxw - 4'd1) : 4'(len_ff - LW'(1));
   assign row       = (tl == 4'd0) ? 2'd0 : (tl <= 4'd2) ? 2'd1 : (tl <= 4'd6) ? 2'd2 : 2'd3;
   assign lg        = dwsm_pkg::chunk_log2(row, align);
   assign slot_nib  = 4'((({32'd0, sctrl_ff}) >> (16 + 4 * int'(idx_ff))) & 64'hF);
   assign hit       = (scount_ff[idx_ff] != 16'd0) && (saddr_ff[idx_ff] == caddr_ff)
                      && (slot_nib == nib_ff);

   always_comb begin
      used_cnt = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (count_ff[i] != 16'd0) used_cnt = used_cnt + CW'(1);
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dwsm_pkg::S_IDLE: begin
            if (req_valid) begin
               if (req_access_type == dwsm_pkg::TYPE_READ ||
                   req_region_length == 7'd0 ||
                   int'(req_region_length) > MAX_REGION_LEN) state_in = dwsm_pkg::S_COMMIT;
               else state_in = dwsm_pkg::S_CHUNK;
            end
         end
         dwsm_pkg::S_CHUNK: begin
            if (status_ff != dwsm_pkg::ST_OK) state_in = dwsm_pkg::S_COMMIT;
            else state_in = dwsm_pkg::S_SCAN;
         end
         dwsm_pkg::S_SCAN:   if (last_slot) state_in = dwsm_pkg::S_APPLY;
         dwsm_pkg::S_APPLY: begin
            if (len_ff <= LW'(csize_ff)) state_in = dwsm_pkg::S_COMMIT;
            else state_in = dwsm_pkg::S_CHUNK;
         end
         dwsm_pkg::S_COMMIT: state_in = dwsm_pkg::S_RESP;
         dwsm_pkg::S_RESP:   if (!rsp_valid_ff || rsp_ready) state_in = dwsm_pkg::S_IDLE;
         default:            state_in = dwsm_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dwsm_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         wide_ff      <= 1'b1;
         ctrl_ff      <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            addr_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_valid) wide_ff <= csr_wide_length_enable;
         if (rsp_valid_ff && rsp_ready && state_ff != dwsm_pkg::S_RESP)
            rsp_valid_ff <= 1'b0;
         case (state_ff)
            dwsm_pkg::S_IDLE: begin
               if (req_valid) begin
                  kind_ff  <= req_kind;
                  type_ff  <= req_access_type;
                  caddr_ff <= req_watch_address;
                  len_ff   <= LW'(req_region_length);
                  sctrl_ff <= ctrl_ff;
                  for (int i = 0; i < SLOTS; i++) begin
                     saddr_ff[i]  <= addr_ff[i];
                     scount_ff[i] <= count_ff[i];
                  end
                  if (req_access_type == dwsm_pkg::TYPE_READ) status_ff <= dwsm_pkg::ST_READ;
                  else if (req_region_length == 7'd0 || int'(req_region_length) > MAX_REGION_LEN)
                     status_ff <= dwsm_pkg::ST_BADLEN;
                  else status_ff <= dwsm_pkg::ST_OK;
               end
            end
            dwsm_pkg::S_CHUNK: begin
               nib_ff   <= dwsm_pkg::rw_len_bits(lg, type_ff);
               csize_ff <= 4'd1 << lg;
               idx_ff   <= '0;
               match_ff <= 1'b0;
               free_ff  <= 1'b0;
            end
            dwsm_pkg::S_SCAN: begin
               if (hit && !match_ff) begin
                  match_ff <= 1'b1;
                  midx_ff  <= idx_ff;
               end
               if (scount_ff[idx_ff] == 16'd0 && !free_ff) begin
                  free_ff <= 1'b1;
                  fidx_ff <= idx_ff;
               end
               if (!last_slot) idx_ff <= idx_ff + SW'(1);
            end
            dwsm_pkg::S_APPLY: begin
               caddr_ff <= caddr_ff + {60'd0, csize_ff};
               len_ff   <= len_ff - LW'(csize_ff);
               if (kind_ff == 1'b0) begin
                  if (match_ff) begin
                     if (scount_ff[midx_ff] == dwsm_pkg::COUNT_MAX)
                        status_ff <= dwsm_pkg::ST_OVERFLOW;
                     else scount_ff[midx_ff] <= scount_ff[midx_ff] + 16'd1;
                  end else if (free_ff) begin
                     saddr_ff[fidx_ff]  <= caddr_ff;
                     scount_ff[fidx_ff] <= 16'd1;
                     sctrl_ff <= 32'(((({32'd0, sctrl_ff}
                        & ~(64'hF << (16 + 4 * int'(fidx_ff))))
                        | ({60'd0, nib_ff} << (16 + 4 * int'(fidx_ff))))
                        | (64'd1 << (2 * int'(fidx_ff)))
                        | {32'd0, dwsm_pkg::SLOWDOWN_BIT})
                        & ~{32'd0, dwsm_pkg::RESERVED_BITS});
                  end else status_ff <= dwsm_pkg::ST_FULL;
               end else begin
                  if (match_ff) begin
                     scount_ff[midx_ff] <= scount_ff[midx_ff] - 16'd1;
                     if (scount_ff[midx_ff] == 16'd1) begin
                        saddr_ff[midx_ff] <= '0;
                        sctrl_ff <= 32'({32'd0, sctrl_ff} & ~(64'd3 << (2 * int'(midx_ff))));
                     end
                  end else status_ff <= dwsm_pkg::ST_NOMATCH;
               end
            end
            dwsm_pkg::S_COMMIT: begin
               if (status_ff == dwsm_pkg::ST_OK) begin
                  ctrl_ff <= sctrl_ff;
                  for (int i = 0; i < SLOTS; i++) begin
                     addr_ff[i]  <= saddr_ff[i];
                     count_ff[i] <= scount_ff[i];
                  end
               end
            end
            dwsm_pkg::S_RESP: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= status_ff;
                  rsp_ctrl_ff   <= ctrl_ff;
                  rsp_used_ff   <= 3'(used_cnt);
               end
            end
            default: ;
         endcase
      end
   end

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != dwsm_pkg::S_IDLE) |-> !req_ready) else $error("ready while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)))
      else $error("response dropped");
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= 3'd5)) else $error("bad status");

endmodule
